// File: hw/rtl/diff_drive_odometry_macros.svh
// Assertion macros for the odometry checker.
// Needs clk and rst in the scope of each use.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("odometry check failed");

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("odometry check failed");

`endif

// File: hw/rtl/ddo_pkg.sv
// Shared constants, codes and helper functions for the odometry block.
// No dependencies.
package ddo_pkg;

  localparam int CORDIC_STEPS  = 24;
  localparam int POS_FRAC_BITS = 24;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int POS_W         = 48;
  localparam int CW            = 34;
  localparam int ZW            = 33;
  localparam int DIST_SH       = 33 - POS_FRAC_BITS;
  localparam int CM_W          = 56;

  localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
  localparam logic [31:0] HEAD_FINISH = 32'h4000_0000;
  localparam logic [31:0] HEAD_BACK   = 32'hC000_0000;
  localparam logic signed [POS_W-1:0] Y_FINISH = POS_W'(5) <<< POS_FRAC_BITS;
  localparam logic [15:0] FULL_CIRCLE = 16'd36000;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_BACK   = 2'd2;

  localparam logic REG_DIST = 1'b0;
  localparam logic REG_TURN = 1'b1;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+5:0] v);
    logic signed [POS_W-1:0] r;
    if (v > $signed({7'd0, {(POS_W-1){1'b1}}})) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < -$signed({6'd0, 1'b1, {(POS_W-1){1'b0}}})) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] clamp_cm(input logic signed [CM_W-1:0] v);
    logic signed [23:0] r;
    if (v > 56'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -56'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/diff_drive_odometry.sv
// Tick: from transaction to result it passes 32 serial multiply steps, a prep step,
// the CORDIC micro-rotations, serial scaling, then update and output formatting.
// Finish and go-back events pass through output formatting only. One item at a time; the next input is
// taken as soon as the result is in the output register; a stalled result adds its stall.
// Synchronous reset clears pose, stored counts, registers and handshake state.
module diff_drive_odometry (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] x_cm,
  output logic signed [23:0] y_cm,
  output logic [15:0]        heading_centideg,
  output logic               accepted,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_CORD  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_FIN1  = 3'd6;
  localparam logic [2:0] S_FIN2  = 3'd7;

  logic [2:0] state;
  logic [31:0] dist_per_count;
  logic [31:0] turn_per_count;
  logic signed [ddo_pkg::POS_W-1:0] pos_x;
  logic signed [ddo_pkg::POS_W-1:0] pos_y;
  logic [31:0] heading;
  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic finished_flag;

  logic [31:0] cur_left;
  logic [31:0] cur_right;
  logic [4:0] cnt;
  logic [32:0] tacc;
  logic [32:0] tdiff;
  logic [31:0] tbits;
  logic [65:0] dprod;
  logic [32:0] msum;
  logic sneg;
  logic [ddo_pkg::POS_W-1:0] mag;
  logic acc;
  logic signed [ddo_pkg::CM_W-1:0] cx;
  logic signed [ddo_pkg::CM_W-1:0] cy;
  logic [47:0] hprod;

  logic [31:0] dl;
  logic [31:0] dr;
  logic [32:0] diff;
  logic [32:0] sum;
  logic [33:0] dsum;
  logic [63:0] drnd;
  logic [63:0] dmag;
  logic cord_start;
  logic cord_done;
  logic signed [ddo_pkg::CW-1:0] cos_v;
  logic signed [ddo_pkg::CW-1:0] sin_v;
  logic scale_start;
  logic sx_done;
  logic sy_done;
  logic signed [52:0] dx;
  logic signed [52:0] dy;
  logic signed [ddo_pkg::POS_W+5:0] nx;
  logic signed [ddo_pkg::POS_W+5:0] ny;
  logic signed [ddo_pkg::CM_W-1:0] px;
  logic signed [ddo_pkg::CM_W-1:0] py;
  logic signed [ddo_pkg::CM_W-1:0] vx;
  logic signed [ddo_pkg::CM_W-1:0] vy;
  logic [47:0] hrnd;

  assign in_stall = (state != S_IDLE);

  assign dl   = left_count - prev_left;
  assign dr   = prev_right - right_count;
  assign diff = {dr[31], dr} - {dl[31], dl};
  assign sum  = {dl[31], dl} + {dr[31], dr};
  assign dsum = dprod[65:32] + (dprod[0] ? {1'b0, msum} : 34'd0);
  assign drnd = dprod[63:0] + (64'd1 << (ddo_pkg::DIST_SH - 1));
  assign dmag = drnd >> ddo_pkg::DIST_SH;

  assign cord_start  = (state == S_PREP);
  assign scale_start = (state == S_CORD) && cord_done;

  assign nx = {{6{pos_x[ddo_pkg::POS_W-1]}}, pos_x} + {dx[52], dx};
  assign ny = {{6{pos_y[ddo_pkg::POS_W-1]}}, pos_y} + {dy[52], dy};
  assign px = {{8{pos_x[ddo_pkg::POS_W-1]}}, pos_x};
  assign py = {{8{pos_y[ddo_pkg::POS_W-1]}}, pos_y};
  assign vx = (cx + (56'sd1 <<< (ddo_pkg::POS_FRAC_BITS - 1))) >>> ddo_pkg::POS_FRAC_BITS;
  assign vy = (cy + (56'sd1 <<< (ddo_pkg::POS_FRAC_BITS - 1))) >>> ddo_pkg::POS_FRAC_BITS;
  assign hrnd = hprod + 48'h8000_0000;

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .ang     (heading + tacc[32:1]),
    .done    (cord_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  ddo_scale u_scale_x (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .mag   (mag),
    .neg   (sneg),
    .comp  (cos_v),
    .done  (sx_done),
    .delta (dx)
  );

  ddo_scale u_scale_y (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .mag   (mag),
    .neg   (sneg),
    .comp  (sin_v),
    .done  (sy_done),
    .delta (dy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      dist_per_count <= '0;
      turn_per_count <= '0;
      pos_x          <= '0;
      pos_y          <= '0;
      heading        <= '0;
      prev_left      <= '0;
      prev_right     <= '0;
      finished_flag  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::REG_DIST: dist_per_count <= cfg_data;
          ddo_pkg::REG_TURN: turn_per_count <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && (state != S_FIN2)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (op == ddo_pkg::OP_TICK) begin
              cur_left  <= left_count;
              cur_right <= right_count;
              tacc      <= '0;
              tdiff     <= diff;
              tbits     <= turn_per_count;
              dprod     <= {34'd0, dist_per_count};
              msum      <= sum[32] ? 33'(-sum) : sum;
              sneg      <= sum[32];
              cnt       <= '0;
              acc       <= 1'b1;
              state     <= S_MUL;
            end else if (op == ddo_pkg::OP_FINISH && !finished_flag) begin
              pos_x         <= '0;
              pos_y         <= ddo_pkg::Y_FINISH;
              heading       <= ddo_pkg::HEAD_FINISH;
              prev_left     <= '0;
              prev_right    <= '0;
              finished_flag <= 1'b1;
              acc           <= 1'b1;
              state         <= S_FIN1;
            end else if (op == ddo_pkg::OP_BACK && finished_flag) begin
              pos_x         <= '0;
              pos_y         <= '0;
              heading       <= ddo_pkg::HEAD_BACK;
              prev_left     <= '0;
              prev_right    <= '0;
              finished_flag <= 1'b0;
              acc           <= 1'b1;
              state         <= S_FIN1;
            end else begin
              acc   <= 1'b0;
              state <= S_FIN1;
            end
          end
        end
        S_MUL: begin
          tacc  <= (tacc << 1) + (tbits[31] ? tdiff : 33'd0);
          tbits <= tbits << 1;
          dprod <= {1'b0, dsum, dprod[31:1]};
          cnt   <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          mag   <= (dmag > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : dmag[47:0];
          state <= S_CORD;
        end
        S_CORD: begin
          if (cord_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (sx_done && sy_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          pos_x      <= ddo_pkg::sat_pos(nx);
          pos_y      <= ddo_pkg::sat_pos(ny);
          heading    <= heading + tacc[31:0];
          prev_left  <= cur_left;
          prev_right <= cur_right;
          state      <= S_FIN1;
        end
        S_FIN1: begin
          cx    <= (px <<< 6) + (px <<< 5) + (px <<< 2);
          cy    <= (py <<< 6) + (py <<< 5) + (py <<< 2);
          hprod <= heading * ddo_pkg::FULL_CIRCLE;
          state <= S_FIN2;
        end
        S_FIN2: begin
          if (!out_valid || !out_stall) begin
            x_cm             <= ddo_pkg::clamp_cm(vx);
            y_cm             <= ddo_pkg::clamp_cm(vy);
            heading_centideg <= (hrnd[47:32] >= ddo_pkg::FULL_CIRCLE) ? 16'd0 : hrnd[47:32];
            accepted         <= acc;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/ddo_cordic.sv
// Iterative rotation CORDIC, one micro-rotation per cycle, quadrant fold.
// Depends on ddo_pkg.
module ddo_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [31:0]                   ang,
  output logic                          done,
  output logic signed [ddo_pkg::CW-1:0] cos_out,
  output logic signed [ddo_pkg::CW-1:0] sin_out
);

  logic signed [ddo_pkg::CW-1:0] x;
  logic signed [ddo_pkg::CW-1:0] y;
  logic signed [ddo_pkg::ZW-1:0] z;
  logic [1:0] q;
  logic [ddo_pkg::STEP_W-1:0] cnt;
  logic run;
  logic [31:0] a;
  logic signed [ddo_pkg::CW-1:0] xs;
  logic signed [ddo_pkg::CW-1:0] ys;
  logic signed [ddo_pkg::ZW-1:0] at;

  assign a  = ang + 32'h2000_0000;
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = $signed({1'b0, ddo_pkg::atan_turn(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x   <= ddo_pkg::INV_GAIN;
        y   <= '0;
        z   <= $signed({3'd0, a[29:0]}) - 33'sd536870912;
        q   <= a[31:30];
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (!z[ddo_pkg::ZW-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (q)
      2'd0: begin
        cos_out = x;
        sin_out = y;
      end
      2'd1: begin
        cos_out = -y;
        sin_out = x;
      end
      2'd2: begin
        cos_out = -x;
        sin_out = -y;
      end
      default: begin
        cos_out = y;
        sin_out = -x;
      end
    endcase
  end

endmodule

// File: hw/rtl/ddo_scale.sv
// Bit-serial scaling of a distance magnitude by a Q30 direction component.
// Depends on ddo_pkg.
module ddo_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ddo_pkg::POS_W-1:0]     mag,
  input  logic                          neg,
  input  logic signed [ddo_pkg::CW-1:0] comp,
  output logic                          done,
  output logic signed [52:0]            delta
);

  logic [64:0] hp;
  logic [48:0] lp;
  logic [31:0] hi;
  logic [15:0] lo;
  logic [32:0] mbits;
  logic [5:0] cnt;
  logic run;
  logic rnd;
  logic sneg;
  logic [ddo_pkg::CW-1:0] cabs;
  logic [32:0] hsum;
  logic [16:0] lsum;
  logic [65:0] tot;

  assign cabs = comp[ddo_pkg::CW-1] ? 34'(-comp) : 34'(comp);
  assign hsum = {1'b0, hp[64:33]} + (mbits[0] ? {1'b0, hi} : 33'd0);
  assign lsum = {1'b0, lp[48:33]} + (mbits[0] ? {1'b0, lo} : 17'd0);
  assign tot  = {1'b0, hp} + {33'd0, lp[48:16]} + 66'd8192;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hp    <= '0;
        lp    <= '0;
        hi    <= mag[47:16];
        lo    <= mag[15:0];
        mbits <= cabs[32:0];
        sneg  <= neg ^ comp[ddo_pkg::CW-1];
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        hp    <= {hsum, hp[32:1]};
        lp    <= {lsum, lp[32:1]};
        mbits <= {1'b0, mbits[32:1]};
        cnt   <= cnt + 1'b1;
        if (cnt == 6'd32) begin
          run <= 1'b0;
          rnd <= 1'b1;
        end
      end else if (rnd) begin
        delta <= sneg ? -$signed({1'b0, tot[65:14]}) : $signed({1'b0, tot[65:14]});
        rnd   <= 1'b0;
        done  <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/ddo_checker.sv
// Port-level checker for diff_drive_odometry, bound to the top level.
// Depends on diff_drive_odometry_macros.svh.
`include "diff_drive_odometry_macros.svh"

module ddo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] x_cm,
  input logic [15:0]        heading_centideg
);

  `DDO_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
  `DDO_ASSERT_IMP(a_heading_range, out_valid, heading_centideg < 16'd36000)
  `DDO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(x_cm))
  `DDO_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

// File: test/odometry_checker.sv
// Pose predictor and result checker for diff_drive_odometry.
// Depends on ddo_pkg; watches the input, output and register ports.
module odometry_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] x_cm,
  input  logic signed [23:0] y_cm,
  input  logic [15:0]        heading_centideg,
  input  logic               accepted,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [15:0] hd;
    logic        acc;
  } pose_t;

  localparam longint POSE_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint POSE_MIN = -64'sh8000_0000_0000;
  localparam longint GAIN_Q30 = 652032874;

  localparam bit [31:0] ANGLE_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  pose_t     expected_poses[$];
  bit [31:0] meters_per_count, turn_per_count;
  longint    pose_x, pose_y;
  bit [31:0] heading, last_left, last_right;
  bit        finished;

  assign pending = expected_poses.size();

  function automatic void rotate(input bit [31:0] angle, output longint c, output longint s);
    bit [31:0] a;
    longint x, y, z, xs, ys;
    a = angle + 32'h2000_0000;
    z = longint'(a[29:0]) - 64'sh2000_0000;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ddo_pkg::CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ANGLE_STEP[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ANGLE_STEP[i]);
      end
    end
    case (a[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint stretch(input bit [63:0] mag, input bit neg, input longint c);
    bit [63:0] cm, r;
    cm = (c < 0) ? -c : c;
    r = ((mag >> 16) * cm + ((mag[15:0] * cm) >> 16) + 64'd8192) >> 14;
    return (neg != (c < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip_pose(input longint v);
    if (v > POSE_MAX) return POSE_MAX;
    if (v < POSE_MIN) return POSE_MIN;
    return v;
  endfunction

  function automatic logic [23:0] to_centimeters(input longint p);
    longint v;
    v = (p * 100 + (64'sd1 <<< (ddo_pkg::POS_FRAC_BITS - 1))) >>> ddo_pkg::POS_FRAC_BITS;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic void dead_reckon(input bit [31:0] l, input bit [31:0] r);
    longint dl, dr, sum, c, s;
    bit [63:0] turn_prod, mag;
    bit [31:0] mid;
    bit neg;
    dl = longint'(signed'(l - last_left));
    dr = longint'(signed'(last_right - r));
    turn_prod = 64'(dr - dl) * 64'(turn_per_count);
    mid = heading + turn_prod[32:1];
    sum = dl + dr;
    neg = sum < 0;
    mag = 64'(neg ? -sum : sum) * 64'(meters_per_count);
    mag = (mag + (64'd1 << (ddo_pkg::DIST_SH - 1))) >> ddo_pkg::DIST_SH;
    if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
    rotate(mid, c, s);
    pose_x = clip_pose(pose_x + stretch(mag, neg, c));
    pose_y = clip_pose(pose_y + stretch(mag, neg, s));
    heading += turn_prod[31:0];
    last_left = l;
    last_right = r;
  endfunction

  function automatic pose_t advance_pose(input logic [1:0] code, input bit [31:0] l,
                                         input bit [31:0] r);
    pose_t p;
    bit [63:0] hd;
    p.acc = 1'b0;
    if (code == ddo_pkg::OP_TICK) begin
      dead_reckon(l, r);
      p.acc = 1'b1;
    end else if (code == ddo_pkg::OP_FINISH && !finished) begin
      pose_x = 0;
      pose_y = 64'sd5 <<< ddo_pkg::POS_FRAC_BITS;
      heading = ddo_pkg::HEAD_FINISH;
      last_left = 0;
      last_right = 0;
      finished = 1'b1;
      p.acc = 1'b1;
    end else if (code == ddo_pkg::OP_BACK && finished) begin
      pose_x = 0;
      pose_y = 0;
      heading = ddo_pkg::HEAD_BACK;
      last_left = 0;
      last_right = 0;
      finished = 1'b0;
      p.acc = 1'b1;
    end
    hd = (64'(heading) * 64'd36000 + 64'h8000_0000) >> 32;
    if (hd >= 36000) hd = 0;
    p.x = to_centimeters(pose_x);
    p.y = to_centimeters(pose_y);
    p.hd = hd[15:0];
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      expected_poses.delete();
      meters_per_count = 0;
      turn_per_count = 0;
      pose_x = 0;
      pose_y = 0;
      heading = 0;
      last_left = 0;
      last_right = 0;
      finished = 0;
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::REG_DIST: meters_per_count = cfg_data;
          ddo_pkg::REG_TURN: turn_per_count = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_poses.push_back(advance_pose(op, left_count, right_count));
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: x %0d y %0d hd %0d acc %0b",
                     x_cm, y_cm, heading_centideg, accepted);
        end else begin
          e = expected_poses.pop_front();
          if (x_cm !== e.x || y_cm !== e.y || heading_centideg !== e.hd ||
              accepted !== e.acc) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"pose mismatch: exp x %0d y %0d hd %0d acc %0b, ",
                        "got x %0d y %0d hd %0d acc %0b"},
                       $signed(e.x), $signed(e.y), e.hd, e.acc,
                       x_cm, y_cm, heading_centideg, accepted);
          end
        end
      end
    end
  end

endmodule

// File: test/tb_diff_drive_odometry.sv
// Stimulus and verdict for diff_drive_odometry: directed extremes, then random walks.
// Depends on ddo_pkg, diff_drive_odometry and odometry_checker.
module tb_diff_drive_odometry;

  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam bit [31:0] DIST_SET [5] = '{32'h0041_8937, 32'h0000_0000, 32'h0100_0000,
                                         32'h0001_0000, 32'h0041_8937};
  localparam bit [31:0] TURN_SET [5] = '{32'h0010_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                                         32'h0000_0000, 32'h0003_0000};

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         op = ddo_pkg::OP_TICK;
  logic signed [31:0] left_count = 0;
  logic signed [31:0] right_count = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [23:0] x_cm, y_cm;
  logic [15:0]        heading_centideg;
  logic               accepted;
  logic               cfg_we = 0;
  logic               cfg_index = ddo_pkg::REG_DIST;
  logic [31:0]        cfg_data = 0;
  int                 mismatches, pending;
  bit                 calm = 0;
  bit [31:0]          wheel_l, wheel_r;

  diff_drive_odometry DUT (.*);
  odometry_checker checker_i (.*);

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && !calm && $urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [1:0] code, input bit [31:0] l, input bit [31:0] r);
    in_valid <= 1'b1;
    op <= code;
    left_count <= l;
    right_count <= r;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_scales(input bit [31:0] dist_step, input bit [31:0] turn_step);
    cfg_we <= 1'b1;
    cfg_index <= ddo_pkg::REG_DIST;
    cfg_data <= dist_step;
    @(posedge clk);
    cfg_index <= ddo_pkg::REG_TURN;
    cfg_data <= turn_step;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send(ddo_pkg::OP_FINISH, $urandom, $urandom);
    end else if (pick < 8) begin
      send(ddo_pkg::OP_BACK, $urandom, $urandom);
    end else if (pick < 9) begin
      send(OP_SPARE, $urandom, $urandom);
    end else if (pick < 17) begin
      wheel_l = $urandom;
      wheel_r = $urandom;
      send(ddo_pkg::OP_TICK, wheel_l, wheel_r);
    end else begin
      wheel_l += $urandom_range(0, 4000) - 2000;
      wheel_r -= $urandom_range(0, 4000) - 2000;
      send(ddo_pkg::OP_TICK, wheel_l, wheel_r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ddo_pkg::OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
    send(ddo_pkg::OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF);
    send(ddo_pkg::OP_TICK, 32'h8000_0000, 32'h8000_0000);
    send(ddo_pkg::OP_TICK, 32'hFFFF_FFFF, 32'h0000_0001);
    send(ddo_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000);
    send(ddo_pkg::OP_TICK, 32'h7FFF_FFFF, 32'h8000_0001);
    send(ddo_pkg::OP_TICK, 32'hFFFF_FFFF, 32'h8000_0000);
    send(ddo_pkg::OP_TICK, 32'h0000_0000, 32'h7FFF_FFFF);
    send(ddo_pkg::OP_BACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ddo_pkg::OP_FINISH, 32'hFFFF_FFFF, 32'h0000_0000);
    send(ddo_pkg::OP_FINISH, 32'h0000_0000, 32'hFFFF_FFFF);
    send(OP_SPARE, 32'h1234_5678, 32'h8765_4321);
    send(ddo_pkg::OP_TICK, 32'h0000_0010, 32'hFFFF_FFF0);
    send(ddo_pkg::OP_BACK, 32'h5555_5555, 32'hAAAA_AAAA);
    send(ddo_pkg::OP_BACK, 32'h0, 32'h0);
    send(ddo_pkg::OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF);
    send(ddo_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000);
    send(ddo_pkg::OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    set_scales(32'h0000_0000, 32'h0000_0000);
    send(ddo_pkg::OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
    send(ddo_pkg::OP_TICK, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    wheel_l = 0;
    wheel_r = 0;
    for (int ph = 0; ph < 5; ph++) begin
      set_scales(DIST_SET[ph], TURN_SET[ph]);
      if (ph == 4) calm = 1;
      repeat (175) random_item();
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
